/* sv/asbh_pkg.sv */
// shared types, constants and register indexes of the scrolling bar history unit
package asbh_pkg;

  localparam int COLUMNS_DEF     = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int DIV_STEPS       = 16;

  localparam logic [4:0] SUB_STEPS_MAX = 5'd16;

  localparam logic [2:0] REG_DIRECTION    = 3'd0;
  localparam logic [2:0] REG_GRAPHIC_MODE = 3'd1;
  localparam logic [2:0] REG_SUB_STEPS    = 3'd2;
  localparam logic [2:0] REG_COLUMNS      = 3'd3;
  localparam logic [2:0] REG_FIXED_LOW    = 3'd4;
  localparam logic [2:0] REG_FIXED_HIGH   = 3'd5;

  localparam logic [4:0] SUB_STEPS_RST = 5'd8;
  localparam logic [6:0] COLUMNS_RST   = 7'd10;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_SAT,
    MODE_DIV
  } mode_t;

  typedef struct packed {
    logic       direction;
    logic       graphic_mode;
    logic [4:0] sub_steps;
    logic [6:0] columns_in_use;
    logic       fixed_low_enable;
    logic       fixed_high_enable;
  } cfg_t;

  typedef struct packed {
    logic        take;
    logic [4:0]  offset;
    mode_t       mode;
    logic [15:0] num;
    logic [15:0] den;
  } cmd_t;

endpackage

/* sv/autorange_scrolling_bar_history_unit.sv */
// top level of the auto-ranging scrolling bar history unit
//
//  channel  direction  handshake                 payload
//  in_      slave      in_tvalid / in_tready     tdata: sample, fixed_low, fixed_high
//  out_     master     out_tvalid / out_tready   tdata: index, level, offset; tuser; tlast
//  cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a tick passes the front end into the queue, then the back end fetches it, runs
// the bit-serial divider when a quotient is needed, shifts the history and emits
// each column in use in turn on the single output register
// synchronous active-low reset clears bounds, pixel offset, history and queue
// the two-entry queue lets the front end take ticks while a run is stalled
module autorange_scrolling_bar_history_unit import asbh_pkg::*; #(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample, fixed_low, fixed_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // column_index, column_level, scroll_offset, zero pad
  output logic [0:0]  out_tuser,  // sample_taken
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  cfg_t cfg_r;
  logic push, pop, full, empty;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction         <= 1'b0;
      cfg_r.graphic_mode      <= 1'b0;
      cfg_r.sub_steps         <= SUB_STEPS_RST;
      cfg_r.columns_in_use    <= COLUMNS_RST;
      cfg_r.fixed_low_enable  <= 1'b0;
      cfg_r.fixed_high_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION:    cfg_r.direction         <= cfg_data[0];
        REG_GRAPHIC_MODE: cfg_r.graphic_mode      <= cfg_data[0];
        REG_SUB_STEPS:    cfg_r.sub_steps         <= cfg_data[4:0];
        REG_COLUMNS:      cfg_r.columns_in_use    <= cfg_data;
        REG_FIXED_LOW:    cfg_r.fixed_low_enable  <= cfg_data[0];
        REG_FIXED_HIGH:   cfg_r.fixed_high_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  asbh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  asbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  asbh_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (empty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* sv/asbh_front.sv */
// front end: tick accept, pixel offset stepping, bound tracking and divide setup
module asbh_front import asbh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        full
);

  logic signed [15:0] low_r, low_nxt;
  logic signed [15:0] high_r, high_nxt;
  logic [4:0]         offset_r, offset_nxt;

  logic signed [15:0] sample, fix_lo, fix_hi;
  logic signed [15:0] lo, hi;
  logic signed [16:0] num, den;
  logic [4:0]         steps;
  logic [5:0]         off, mag;
  logic               hold, take;
  mode_t              mode;

  assign sample    = signed'(in_tdata[15:0]);
  assign fix_lo    = signed'(in_tdata[31:16]);
  assign fix_hi    = signed'(in_tdata[47:32]);
  assign in_tready = !full;
  assign push      = in_tvalid && !full;

  always_comb begin
    steps = (cfg.sub_steps > SUB_STEPS_MAX) ? SUB_STEPS_MAX : cfg.sub_steps;
    off   = {offset_r[4], offset_r} + (cfg.direction ? 6'h3f : 6'h01);
    mag   = off[5] ? 6'(-off) : off;
    hold  = cfg.graphic_mode && (mag < {1'b0, steps});
    take  = !hold;

    offset_nxt = offset_r;
    if (cfg.graphic_mode) begin
      offset_nxt = hold ? off[4:0] : 5'd0;
    end

    if (cfg.fixed_low_enable) begin
      lo = fix_lo;
    end else begin
      lo = (sample < low_r) ? sample : low_r;
    end
    if (cfg.fixed_high_enable) begin
      hi = fix_hi;
    end else begin
      hi = (sample > high_r) ? sample : high_r;
    end

    num = 17'({sample[15], sample}) - 17'({lo[15], lo});
    den = 17'({hi[15], hi}) - 17'({lo[15], lo});

    if (den <= 17'sd0 || num <= 17'sd0) begin
      mode = MODE_ZERO;
    end else if (num >= den) begin
      mode = MODE_SAT;
    end else begin
      mode = MODE_DIV;
    end

    low_nxt  = take ? lo : low_r;
    high_nxt = take ? hi : high_r;

    push_cmd.take   = take;
    push_cmd.offset = offset_nxt;
    push_cmd.mode   = mode;
    push_cmd.num    = num[15:0];
    push_cmd.den    = den[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= '0;
      offset_r <= '0;
    end else if (push) begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

/* sv/asbh_queue.sv */
// short command queue between front and back end
module asbh_queue import asbh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/asbh_back.sv */
// back end: serial divider, history shift line and column run output
module asbh_back import asbh_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [0:0]  out_tuser,
  output logic        out_tlast
);

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int COL_W = $clog2(COLUMNS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      level_r, level_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      hist_r [COLUMNS];
  logic [15:0]      hist_nxt [COLUMNS];

  logic             out_valid_r, out_valid_nxt;
  logic [5:0]       out_index_r, out_index_nxt;
  logic [15:0]      out_level_r, out_level_nxt;
  logic [4:0]       out_off_r, out_off_nxt;
  logic             out_take_r, out_take_nxt;
  logic             out_last_r, out_last_nxt;

  logic [COL_W-1:0] cols;
  logic [IDX_W-1:0] last_idx;
  logic [16:0]      r2;
  logic             qbit;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_off_r, out_level_r, out_index_r};
  assign out_tuser  = out_take_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    if (cfg.columns_in_use == 7'd0) begin
      cols = COL_W'(1);
    end else if (cfg.columns_in_use > 7'(COLUMNS)) begin
      cols = COL_W'(COLUMNS);
    end else begin
      cols = COL_W'(cfg.columns_in_use);
    end
    last_idx = IDX_W'(cols - 1'b1);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rem_nxt       = rem_r;
    level_nxt     = level_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_level_nxt = out_level_r;
    out_off_nxt   = out_off_r;
    out_take_nxt  = out_take_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    r2            = {rem_r, 1'b0};
    qbit          = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          cnt_nxt = '0;
          case (q_cmd.mode)
            MODE_DIV: begin
              rem_nxt   = q_cmd.num;
              level_nxt = '0;
              state_nxt = ST_DIV;
            end
            MODE_SAT: begin
              level_nxt = '1;
              state_nxt = ST_SHIFT;
            end
            default: begin
              level_nxt = '0;
              state_nxt = ST_SHIFT;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (r2 >= {1'b0, cmd_r.den}) begin
          rem_nxt = 16'(r2 - {1'b0, cmd_r.den});
          qbit    = 1'b1;
        end else begin
          rem_nxt = r2[15:0];
        end
        level_nxt = {level_r[14:0], qbit};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cmd_r.take) begin
          for (int j = 0; j < COLUMNS; j++) begin
            if (!cfg.direction) begin
              if (j == 0) begin
                hist_nxt[j] = level_r;
              end else if (IDX_W'(j) <= last_idx) begin
                hist_nxt[j] = hist_r[j-1];
              end
            end else begin
              if (IDX_W'(j) == last_idx) begin
                hist_nxt[j] = level_r;
              end else if (IDX_W'(j) < last_idx && j < COLUMNS - 1) begin
                hist_nxt[j] = hist_r[j+1];
              end
            end
          end
        end
        idx_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = 6'(idx_r);
          out_level_nxt = hist_r[0];
          out_off_nxt   = cmd_r.offset;
          out_take_nxt  = cmd_r.take;
          out_last_nxt  = (idx_r == last_idx);
          // rotate the columns in use so the next one sits at the head
          for (int j = 0; j < COLUMNS; j++) begin
            if (IDX_W'(j) == last_idx) begin
              hist_nxt[j] = hist_r[0];
            end else if (IDX_W'(j) < last_idx && j < COLUMNS - 1) begin
              hist_nxt[j] = hist_r[j+1];
            end
          end
          idx_nxt = idx_r + 1'b1;
          if (idx_r == last_idx) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int j = 0; j < COLUMNS; j++) begin
        hist_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
    cmd_r       <= cmd_nxt;
    rem_r       <= rem_nxt;
    level_r     <= level_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    out_index_r <= out_index_nxt;
    out_level_r <= out_level_nxt;
    out_off_r   <= out_off_nxt;
    out_take_r  <= out_take_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

/* sv/asbh_checker.sv */
// port checker of the scrolling bar history unit and its bind
module asbh_checker import asbh_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // column index stays inside the history
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= 6'(COLUMNS - 1))
    else $error("column index beyond history");

  // pixel offset never reaches a full column step and the padding stays zero
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:22] != 5'b10000 && out_tdata[31:27] == 5'd0)
    else $error("scroll offset or padding out of range");

endmodule

bind autorange_scrolling_bar_history_unit asbh_checker #(
  .COLUMNS (COLUMNS)
) u_asbh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/autorange_scrolling_bar_history_unit_tb.sv */
// testbench of the auto-ranging scrolling bar history unit: directed and random ticks checked against a predictor
`timescale 1ns / 100ps

module autorange_scrolling_bar_history_unit_tb;
  import asbh_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 30;

  typedef struct packed {
    logic signed [15:0] fixed_high;
    logic signed [15:0] fixed_low;
    logic signed [15:0] sample;
  } tick_t;

  typedef struct packed {
    logic [5:0]  index;
    logic [15:0] level;
    logic [4:0]  offset;
    logic        taken;
    logic        last;
  } column_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // sample, fixed_low, fixed_high
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // column_index, column_level, scroll_offset, zero pad
  logic [0:0]  out_tuser;       // sample_taken
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  tick_t   pending_ticks[$];
  column_t expected_columns[$];

  // register copy
  logic       cfg_dir = 1'b0;
  logic       cfg_gfx = 1'b0;
  logic [4:0] cfg_steps = SUB_STEPS_RST;
  logic [6:0] cfg_cols = COLUMNS_RST;
  logic       cfg_fix_lo = 1'b0;
  logic       cfg_fix_hi = 1'b0;

  // predicted block state
  logic signed [15:0] low_bound = '0;
  logic signed [15:0] high_bound = '0;
  logic signed [4:0]  scroll_pos = '0;
  logic [15:0]        history[COLUMNS];

  int          ticks_accepted = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic [31:0] cycle_count = '0;
  logic        idle_allowed;

  autorange_scrolling_bar_history_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one window in four has no idling on either side
  assign idle_allowed = cycle_count[11:10] != 2'd1;

  function automatic logic [15:0] level_of(int s, int lo, int hi);
    longint span;
    longint num;
    longint q;
    span = longint'(hi) - longint'(lo);
    num  = longint'(s) - longint'(lo);
    if (span <= 0 || num <= 0) return 16'd0;
    q = (num * 65536) / span;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic string describe(column_t c);
    return $sformatf("col %0d level %h offset %h taken %b last %b",
                     c.index, c.level, c.offset, c.taken, c.last);
  endfunction

  task automatic predict_tick(tick_t t);
    int cols;
    int steps;
    int off;
    int mag;
    int i;
    logic [15:0] lvl;
    logic take;
    column_t r;
    cols = int'(cfg_cols);
    if (cols < 1) cols = 1;
    if (cols > COLUMNS) cols = COLUMNS;
    steps = (cfg_steps > SUB_STEPS_MAX) ? int'(SUB_STEPS_MAX) : int'(cfg_steps);
    take = 1'b1;
    if (cfg_gfx) begin
      off = int'(scroll_pos) + (cfg_dir ? -1 : 1);
      mag = (off < 0) ? -off : off;
      if (mag < steps) begin
        scroll_pos = off[4:0];
        take = 1'b0;
      end else begin
        scroll_pos = '0;
      end
    end
    if (take) begin
      low_bound  = cfg_fix_lo ? t.fixed_low : ((t.sample < low_bound) ? t.sample : low_bound);
      high_bound = cfg_fix_hi ? t.fixed_high : ((t.sample > high_bound) ? t.sample : high_bound);
      lvl = level_of(t.sample, low_bound, high_bound);
      if (!cfg_dir) begin
        for (i = cols - 1; i > 0; i--) history[i] = history[i - 1];
        history[0] = lvl;
      end else begin
        for (i = 0; i < cols - 1; i++) history[i] = history[i + 1];
        history[cols - 1] = lvl;
      end
    end
    for (i = 0; i < cols; i++) begin
      r.index  = i[5:0];
      r.level  = history[i];
      r.offset = scroll_pos;
      r.taken  = take;
      r.last   = (i == cols - 1);
      expected_columns.insert(expected_columns.size(), r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tick(tick_t'(in_tdata));
        ticks_accepted <= ticks_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && !(idle_allowed && $urandom_range(0, 99) < 25)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_ticks.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && ticks_accepted >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_allowed && $urandom_range(0, 99) < 25);
    end
  end

  // monitor
  always @(posedge clk) begin
    column_t seen;
    column_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.index  = out_tdata[5:0];
      seen.level  = out_tdata[21:6];
      seen.offset = out_tdata[26:22];
      seen.taken  = out_tuser[0];
      seen.last   = out_tlast;
      if (expected_columns.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected transaction: got %s", describe(seen));
        mismatch_count++;
      end else begin
        want = expected_columns.pop_front();
        if (seen !== want) begin
          if (mismatch_count < 10)
            $display("mismatch: expected %s, got %s", describe(want), describe(seen));
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIRECTION:    cfg_dir    = val[0];
      REG_GRAPHIC_MODE: cfg_gfx    = val[0];
      REG_SUB_STEPS:    cfg_steps  = val[4:0];
      REG_COLUMNS:      cfg_cols   = val;
      REG_FIXED_LOW:    cfg_fix_lo = val[0];
      REG_FIXED_HIGH:   cfg_fix_hi = val[0];
      default: ;
    endcase
  endtask

  task automatic write_setting(logic dir, logic gfx, logic [4:0] steps, logic [6:0] cols,
                               logic fix_lo, logic fix_hi);
    write_reg(REG_DIRECTION, {6'd0, dir});
    write_reg(REG_GRAPHIC_MODE, {6'd0, gfx});
    write_reg(REG_SUB_STEPS, {2'd0, steps});
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_FIXED_LOW, {6'd0, fix_lo});
    write_reg(REG_FIXED_HIGH, {6'd0, fix_hi});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_tvalid || expected_columns.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_tick(int s, int lo, int hi);
    tick_t t;
    t.sample     = s[15:0];
    t.fixed_low  = lo[15:0];
    t.fixed_high = hi[15:0];
    pending_ticks.insert(pending_ticks.size(), t);
  endtask

  initial begin
    logic [4:0] steps;
    logic [6:0] cols;
    tick_t t;
    logic signed [15:0] swap;
    int pick;
    foreach (history[k]) history[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting, auto range: empty span, full scale, negative extreme
    queue_tick(0, 0, 0);
    queue_tick(32767, 0, 0);
    queue_tick(-32768, 0, 0);
    queue_tick(0, 0, 0);
    queue_tick(-1, 0, 0);
    queue_tick(32767, 0, 0);
    wait_drained();

    // west, graphic, one column, fixed bounds: saturation both ways
    write_setting(1'b1, 1'b1, 5'd3, 7'd1, 1'b1, 1'b1);
    queue_tick(7, 1000, -1000);
    queue_tick(-7, 3, 3);
    queue_tick(100, -50, 50);
    queue_tick(12, 0, 100);
    queue_tick(-12, 0, 100);
    queue_tick(-100, -50, 50);
    wait_drained();

    // zero columns, zero steps: full range and empty or inverted fixed span
    write_setting(1'b0, 1'b1, 5'd0, 7'd0, 1'b1, 1'b1);
    queue_tick(32767, -32768, 32767);
    queue_tick(5, 10, 10);
    queue_tick(-32768, -32768, 32767);
    queue_tick(0, 20, -20);
    wait_drained();

    // oversized step and column counts clamp, offset climbs east
    write_setting(1'b0, 1'b1, 5'd31, 7'd127, 1'b0, 1'b0);
    queue_tick(1234, 0, 0);
    queue_tick(-4321, 0, 0);
    queue_tick(32767, 0, 0);
    queue_tick(-32768, 0, 0);
    wait_drained();

    // graphic off keeps the offset, every tick takes
    write_setting(1'b1, 1'b0, 5'd16, 7'd64, 1'b1, 1'b0);
    queue_tick(300, -32768, 0);
    queue_tick(-32768, 32767, 0);
    queue_tick(32767, -1, 0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      pick = $urandom_range(0, 9);
      steps = (pick == 0) ? 5'($urandom_range(17, 31)) :
              (pick == 1) ? 5'd0 : 5'($urandom_range(1, 16));
      pick = $urandom_range(0, 9);
      cols = (pick == 0) ? 7'd0 :
             (pick == 1) ? 7'($urandom_range(33, 127)) :
             (pick < 4)  ? 7'($urandom_range(13, 32)) : 7'($urandom_range(1, 12));
      if (p == 0) begin
        steps = 5'd1;
        cols  = 7'd32;
      end
      write_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), steps, cols,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int n = 0; n < 18; n++) begin
        t.sample = 16'($urandom());
        if ($urandom_range(0, 9) == 0)
          t.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        t.fixed_low  = 16'($urandom());
        t.fixed_high = 16'($urandom());
        if ($urandom_range(0, 99) < 85 && t.fixed_low > t.fixed_high) begin
          swap         = t.fixed_low;
          t.fixed_low  = t.fixed_high;
          t.fixed_high = swap;
        end
        pending_ticks.insert(pending_ticks.size(), t);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/asbh_pkg.sv
sv/asbh_front.sv
sv/asbh_queue.sv
sv/asbh_back.sv
sv/autorange_scrolling_bar_history_unit.sv
sv/asbh_checker.sv
tb/autorange_scrolling_bar_history_unit_tb.sv
